>>> hw/rtl/button_press_blink_controller_defines.svh
// Assertion macros used by the button blink controller checker
`ifndef BUTTON_PRESS_BLINK_CONTROLLER_DEFINES_SVH
`define BUTTON_PRESS_BLINK_CONTROLLER_DEFINES_SVH

// Same-cycle implication, held off while reset is asserted
`define BPBC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("bpbc assertion failed");

// Next-cycle implication, held off while reset is asserted
`define BPBC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("bpbc assertion failed");

`endif

>>> hw/rtl/bpbc_pkg.sv
// Types, codes and reset values for the button blink controller
package bpbc_pkg;

    localparam int TIMER_BITS_DEF = 16;
    localparam int CFG_W          = 16;
    localparam int APB_DW         = 32;
    localparam int APB_AW         = 5;
    localparam int S_TDATA_W      = 8;
    localparam int M_TDATA_W      = 8;
    localparam int REG_IDX_W      = 3;

    typedef enum logic [1:0] {
        PH_IDLE     = 2'd0,
        PH_DEBOUNCE = 2'd1,
        PH_HELD     = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        EV_NONE  = 2'd0,
        EV_SHORT = 2'd1,
        EV_LONG  = 2'd2
    } press_ev_t;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_DEBOUNCE   = 3'd0,
        REG_LONG_PRESS = 3'd1,
        REG_HALF_SLOW  = 3'd2,
        REG_HALF_MID   = 3'd3,
        REG_HALF_FAST  = 3'd4
    } reg_idx_t;

    localparam logic [1:0] RATE_SLOW = 2'd0;
    localparam logic [1:0] RATE_MID  = 2'd1;
    localparam logic [1:0] RATE_FAST = 2'd2;

    localparam logic [CFG_W-1:0] DEBOUNCE_RST   = 16'd50;
    localparam logic [CFG_W-1:0] LONG_PRESS_RST = 16'd1000;
    localparam logic [CFG_W-1:0] HALF_SLOW_RST  = 16'd500;
    localparam logic [CFG_W-1:0] HALF_MID_RST   = 16'd250;
    localparam logic [CFG_W-1:0] HALF_FAST_RST  = 16'd125;

    // Result beat, led_on in the lowest bit
    typedef struct packed {
        press_ev_t  press_event;
        logic [1:0] rate_index;
        logic       blinking;
        logic       led_on;
    } out_beat_t;

    localparam int OUT_BEAT_W = $bits(out_beat_t);

endpackage

>>> hw/rtl/button_press_blink_controller.sv
// Debounced short/long press LED blinker: one beat per millisecond tick, one result per beat.
// Each input beat is one tick carrying the sampled active-low button level; each accepted
// beat yields exactly one result beat with the LED level, blink enable, rate index and the
// press event of that tick. A beat is taken every clock cycle while the sink takes results:
// the whole tick update is a single pass of compare and increment logic from the state
// registers into the state and the output register, so the sustained rate is one tick per
// cycle and each result is registered. The output register holds a result while the sink
// stalls; s_tready is high whenever that register is empty or being emptied in the same
// cycle. The five timing registers (debounce, long press, three half periods) sit on the APB
// port at byte offsets 0x00 to 0x10, 16 bits each; write them only while the block is idle.
module button_press_blink_controller #(
    parameter int TIMER_BITS = bpbc_pkg::TIMER_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // tdata: [0] button_level, [7:1] zero
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [bpbc_pkg::S_TDATA_W-1:0] s_tdata,
    // tdata: [0] led_on, [1] blinking, [3:2] rate_index, [5:4] press_event, [7:6] zero
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [bpbc_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [bpbc_pkg::APB_AW-1:0]    paddr,
    input  logic [bpbc_pkg::APB_DW-1:0]    pwdata,
    output logic [bpbc_pkg::APB_DW-1:0]    prdata,
    output logic                           pready
);
    import bpbc_pkg::*;

    localparam int CMP_W = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;

    typedef logic [TIMER_BITS-1:0] timer_t;

    function automatic timer_t timer_inc(input timer_t t);
        timer_inc = (&t) ? t : t + TIMER_BITS'(1);
    endfunction

    // Configuration registers
    logic [CFG_W-1:0] debounce_ticks_reg;
    logic [CFG_W-1:0] long_press_ticks_reg;
    logic [CFG_W-1:0] half_period_slow_reg;
    logic [CFG_W-1:0] half_period_mid_reg;
    logic [CFG_W-1:0] half_period_fast_reg;

    // Tick state
    logic       prev_level_reg, prev_level_next;
    phase_t     phase_reg, phase_next;
    timer_t     debounce_elapsed_reg, debounce_elapsed_next;
    timer_t     hold_elapsed_reg, hold_elapsed_next;
    logic       long_done_reg, long_done_next;
    logic       blink_on_reg, blink_on_next;
    logic       led_level_reg, led_level_next;
    logic [1:0] rate_sel_reg, rate_sel_next;
    timer_t     toggle_elapsed_reg, toggle_elapsed_next;
    press_ev_t  event_next;

    logic       m_valid_reg;
    out_beat_t  m_beat_reg, m_beat_next;

    logic             level;
    logic             s_accept;
    logic             cfg_write;
    logic [CFG_W-1:0] half_sel;
    reg_idx_t         reg_idx;

    assign level     = s_tdata[0];
    assign s_tready  = !m_valid_reg || m_tready;
    assign s_accept  = s_tvalid && s_tready;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {(M_TDATA_W - OUT_BEAT_W)'(0), m_beat_reg};

    // ---------------- APB port ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_idx   = reg_idx_t'(paddr[REG_IDX_W+1:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_ticks_reg   <= DEBOUNCE_RST;
            long_press_ticks_reg <= LONG_PRESS_RST;
            half_period_slow_reg <= HALF_SLOW_RST;
            half_period_mid_reg  <= HALF_MID_RST;
            half_period_fast_reg <= HALF_FAST_RST;
        end else if (cfg_write) begin
            case (reg_idx)
                REG_DEBOUNCE:   debounce_ticks_reg   <= pwdata[CFG_W-1:0];
                REG_LONG_PRESS: long_press_ticks_reg <= pwdata[CFG_W-1:0];
                REG_HALF_SLOW:  half_period_slow_reg <= pwdata[CFG_W-1:0];
                REG_HALF_MID:   half_period_mid_reg  <= pwdata[CFG_W-1:0];
                REG_HALF_FAST:  half_period_fast_reg <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_DEBOUNCE:   prdata = APB_DW'(debounce_ticks_reg);
            REG_LONG_PRESS: prdata = APB_DW'(long_press_ticks_reg);
            REG_HALF_SLOW:  prdata = APB_DW'(half_period_slow_reg);
            REG_HALF_MID:   prdata = APB_DW'(half_period_mid_reg);
            REG_HALF_FAST:  prdata = APB_DW'(half_period_fast_reg);
            default:        prdata = '0;
        endcase
    end

    // ---------------- next state ----------------
    always_comb begin
        prev_level_next       = level;
        phase_next            = phase_reg;
        debounce_elapsed_next = debounce_elapsed_reg;
        hold_elapsed_next     = hold_elapsed_reg;
        long_done_next        = long_done_reg;
        blink_on_next         = blink_on_reg;
        led_level_next        = led_level_reg;
        rate_sel_next         = rate_sel_reg;
        toggle_elapsed_next   = toggle_elapsed_reg;
        event_next            = EV_NONE;

        // Edge detector runs only in idle
        case (phase_reg)
            PH_DEBOUNCE, PH_HELD: ;
            default: begin
                phase_next = PH_IDLE;
                if (prev_level_reg && !level) begin
                    phase_next            = PH_DEBOUNCE;
                    debounce_elapsed_next = '0;
                end
            end
        endcase

        if (phase_next == PH_DEBOUNCE) begin
            if (CMP_W'(debounce_elapsed_next) >= CMP_W'(debounce_ticks_reg)) begin
                if (!level) begin
                    phase_next        = PH_HELD;
                    hold_elapsed_next = '0;
                    long_done_next    = 1'b0;
                end else begin
                    phase_next = PH_IDLE;
                end
            end else begin
                debounce_elapsed_next = timer_inc(debounce_elapsed_next);
            end
        end

        if (phase_next == PH_HELD) begin
            if (!level && !long_done_next &&
                CMP_W'(hold_elapsed_next) >= CMP_W'(long_press_ticks_reg)) begin
                rate_sel_next       = (rate_sel_reg >= RATE_FAST) ? RATE_SLOW
                                                                  : rate_sel_reg + 2'd1;
                toggle_elapsed_next = '0;
                long_done_next      = 1'b1;
                event_next          = EV_LONG;
            end
            if (level) begin
                phase_next = PH_IDLE;
                if (!long_done_next) begin
                    blink_on_next       = !blink_on_reg;
                    led_level_next      = !blink_on_reg;
                    toggle_elapsed_next = '0;
                    event_next          = EV_SHORT;
                end
            end else begin
                hold_elapsed_next = timer_inc(hold_elapsed_next);
            end
        end

        case (rate_sel_next)
            RATE_MID:  half_sel = half_period_mid_reg;
            RATE_FAST: half_sel = half_period_fast_reg;
            default:   half_sel = half_period_slow_reg;
        endcase

        if (blink_on_next && CMP_W'(toggle_elapsed_next) >= CMP_W'(half_sel)) begin
            led_level_next      = !led_level_next;
            toggle_elapsed_next = '0;
        end
        toggle_elapsed_next = timer_inc(toggle_elapsed_next);
    end

    // ---------------- result beat ----------------
    always_comb begin
        m_beat_next.led_on      = led_level_next;
        m_beat_next.blinking    = blink_on_next;
        m_beat_next.rate_index  = rate_sel_next;
        m_beat_next.press_event = event_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_level_reg       <= 1'b1;
            phase_reg            <= PH_IDLE;
            debounce_elapsed_reg <= '0;
            hold_elapsed_reg     <= '0;
            long_done_reg        <= 1'b0;
            blink_on_reg         <= 1'b0;
            led_level_reg        <= 1'b0;
            rate_sel_reg         <= RATE_SLOW;
            toggle_elapsed_reg   <= '0;
        end else if (s_accept) begin
            prev_level_reg       <= prev_level_next;
            phase_reg            <= phase_next;
            debounce_elapsed_reg <= debounce_elapsed_next;
            hold_elapsed_reg     <= hold_elapsed_next;
            long_done_reg        <= long_done_next;
            blink_on_reg         <= blink_on_next;
            led_level_reg        <= led_level_next;
            rate_sel_reg         <= rate_sel_next;
            toggle_elapsed_reg   <= toggle_elapsed_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Payload: load on every accepted beat, hold otherwise
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            m_beat_reg <= m_beat_next;
        end
    end

endmodule

>>> hw/rtl/bpbc_checker.sv
// Port-level checks for the button blink controller, bound to the top level
`include "button_press_blink_controller_defines.svh"

module bpbc_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [bpbc_pkg::M_TDATA_W-1:0] m_tdata
);
    import bpbc_pkg::*;

    // A stalled result holds its value
    `BPBC_ASSERT_NEXT(a_stall_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    // Rate index never leaves the three rates
    `BPBC_ASSERT_IMPL(a_rate_range, aclk, aresetn, m_tvalid, m_tdata[3:2] <= RATE_FAST)
    // An accepted tick yields a result beat in the next cycle
    `BPBC_ASSERT_NEXT(a_accept_valid, aclk, aresetn, s_tvalid && s_tready, m_tvalid)
    // LED stays dark while blinking is off
    `BPBC_ASSERT_IMPL(a_led_off, aclk, aresetn, m_tvalid && !m_tdata[1], !m_tdata[0])

endmodule

bind button_press_blink_controller bpbc_checker u_bpbc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
